FILE: hw/rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared constants, command codes and controller/datapath structs for the
// path time interval estimator.
// ----------------------------------------------------------------------------
package pte_pkg;

  // path capacity and derived widths
  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int BIDX_W     = $clog2(MAX_POINTS);

  // nearness window, Q16.16 meters
  localparam int NEAR_M = 1000;
  localparam int NEAR_W = 26;
  localparam int D2_W   = 2 * NEAR_W + 1;
  localparam logic [NEAR_W-1:0] NEAR_RAW = NEAR_W'(NEAR_M * 65536);
  localparam logic [D2_W-1:0]   NEAR_D2  =
    D2_W'(longint'(NEAR_RAW) * longint'(NEAR_RAW));

  // iterative unit sizes
  localparam int DIV_N  = 64;
  localparam int SQRT_N = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd5;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEG_MA,
    OP_SEG_MB,
    OP_SEG_SQ,
    OP_NEAR_A,
    OP_NEAR_B,
    OP_UPDATE,
    OP_DIST_SQ,
    OP_VM2,
    OP_V02,
    OP_V12,
    OP_TA,
    OP_TD,
    OP_DA,
    OP_DD,
    OP_CRUISE,
    OP_AD,
    OP_PEAK_SQ,
    OP_PEAK_DIV,
    OP_SEGS_DIV,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic div_done;
    logic sqrt_done;
    logic need_time;
    logic speed_bad;
    logic cruise;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/pte_if.sv
// ----------------------------------------------------------------------------
// pte_if
// Valid/ready channels for path points in and estimates out.
// ----------------------------------------------------------------------------
interface pte_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pte_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        nearest_index;
  logic signed [31:0] nearest_x;
  logic signed [31:0] nearest_y;
  logic [31:0]        nearest_distance;
  logic [31:0]        segment_time;
  logic               status;

  modport source (output valid, nearest_index, nearest_x, nearest_y, nearest_distance,
                  segment_time, status, input ready);
  modport sink   (input valid, nearest_index, nearest_x, nearest_y, nearest_distance,
                  segment_time, status, output ready);
endinterface

FILE: hw/rtl/pte_div.sv
// ----------------------------------------------------------------------------
// pte_div
// Restoring divider, one quotient bit per cycle; operands load on the first
// cycle of run, done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module pte_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        run,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  localparam int CW = $clog2(pte_pkg::DIV_N + 2);
  localparam logic [CW-1:0] LAST_CNT = CW'(pte_pkg::DIV_N + 1);

  logic [CW-1:0] cnt;
  logic [63:0]   sh;
  logic [31:0]   rem;
  logic [31:0]   den_r;
  logic [32:0]   trial;
  logic          fits;

  assign done  = run && (cnt == LAST_CNT);
  assign quo   = sh;
  assign trial = {rem, sh[63]};
  assign fits  = trial >= {1'b0, den_r};

  // step counter
  always_ff @(posedge clk) begin
    if (rst || !run || done) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(1);
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (run && cnt == '0) begin
      sh    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run && !done) begin
      rem <= fits ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      sh  <= {sh[62:0], fits};
    end
  end

endmodule

FILE: hw/rtl/pte_sqrt.sv
// ----------------------------------------------------------------------------
// pte_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pte_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        run,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  localparam int CW = $clog2(pte_pkg::SQRT_N + 2);
  localparam logic [CW-1:0] LAST_CNT = CW'(pte_pkg::SQRT_N + 1);

  logic [CW-1:0] cnt;
  logic [63:0]   sh;
  logic [33:0]   rem;
  logic [35:0]   nrem;
  logic [35:0]   trial;
  logic          fits;

  assign done  = run && (cnt == LAST_CNT);
  assign nrem  = {rem, sh[63:62]};
  assign trial = 36'({root, 2'b01});
  assign fits  = nrem >= trial;

  // step counter
  always_ff @(posedge clk) begin
    if (rst || !run || done) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(1);
    end
  end

  // one root bit per step
  always_ff @(posedge clk) begin
    if (run && cnt == '0) begin
      sh   <= rad;
      rem  <= '0;
      root <= '0;
    end else if (run && !done) begin
      rem  <= fits ? 34'(nrem - trial) : 34'(nrem);
      root <= {root[30:0], fits};
      sh   <= {sh[61:0], 2'b00};
    end
  end

endmodule

FILE: hw/rtl/pte_ctrl.sv
// ----------------------------------------------------------------------------
// pte_ctrl
// Sequencer: walks each point through segment length and nearness update,
// the last point also through distance and, if a time is due, speed profile timing.
// ----------------------------------------------------------------------------
module pte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  pte_pkg::stat_t stat,
  output pte_pkg::cmd_t  cmd
);

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_SEG_MA   = 22'h000002,
    ST_SEG_MB   = 22'h000004,
    ST_SEG_SQ   = 22'h000008,
    ST_NEAR_A   = 22'h000010,
    ST_NEAR_B   = 22'h000020,
    ST_UPDATE   = 22'h000040,
    ST_DIST_SQ  = 22'h000080,
    ST_VM2      = 22'h000100,
    ST_V02      = 22'h000200,
    ST_V12      = 22'h000400,
    ST_TA       = 22'h000800,
    ST_TD       = 22'h001000,
    ST_DA       = 22'h002000,
    ST_DD       = 22'h004000,
    ST_PICK     = 22'h008000,
    ST_CRUISE   = 22'h010000,
    ST_AD       = 22'h020000,
    ST_PEAK_SQ  = 22'h040000,
    ST_PEAK_DIV = 22'h080000,
    ST_SEGS_DIV = 22'h100000,
    ST_EMIT     = 22'h200000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (stat.in_valid) state_next = ST_SEG_MA;
      ST_SEG_MA:   state_next = ST_SEG_MB;
      ST_SEG_MB:   state_next = ST_SEG_SQ;
      ST_SEG_SQ:   if (stat.sqrt_done) state_next = ST_NEAR_A;
      ST_NEAR_A:   state_next = ST_NEAR_B;
      ST_NEAR_B:   state_next = ST_UPDATE;
      ST_UPDATE:   state_next = stat.last ? ST_DIST_SQ : ST_IDLE;
      ST_DIST_SQ: begin
        if (stat.sqrt_done) begin
          state_next = (stat.need_time && !stat.speed_bad) ? ST_VM2 : ST_EMIT;
        end
      end
      ST_VM2:      state_next = ST_V02;
      ST_V02:      state_next = ST_V12;
      ST_V12:      state_next = ST_TA;
      ST_TA:       if (stat.div_done) state_next = ST_TD;
      ST_TD:       if (stat.div_done) state_next = ST_DA;
      ST_DA:       if (stat.div_done) state_next = ST_DD;
      ST_DD:       if (stat.div_done) state_next = ST_PICK;
      ST_PICK:     state_next = stat.cruise ? ST_CRUISE : ST_AD;
      ST_CRUISE:   if (stat.div_done) state_next = ST_SEGS_DIV;
      ST_AD:       state_next = ST_PEAK_SQ;
      ST_PEAK_SQ:  if (stat.sqrt_done) state_next = ST_PEAK_DIV;
      ST_PEAK_DIV: if (stat.div_done) state_next = ST_SEGS_DIV;
      ST_SEGS_DIV: if (stat.div_done) state_next = ST_EMIT;
      ST_EMIT:     if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    unique case (state)
      ST_IDLE:     cmd.op = pte_pkg::OP_LOAD;
      ST_SEG_MA:   cmd.op = pte_pkg::OP_SEG_MA;
      ST_SEG_MB:   cmd.op = pte_pkg::OP_SEG_MB;
      ST_SEG_SQ:   cmd.op = pte_pkg::OP_SEG_SQ;
      ST_NEAR_A:   cmd.op = pte_pkg::OP_NEAR_A;
      ST_NEAR_B:   cmd.op = pte_pkg::OP_NEAR_B;
      ST_UPDATE:   cmd.op = pte_pkg::OP_UPDATE;
      ST_DIST_SQ:  cmd.op = pte_pkg::OP_DIST_SQ;
      ST_VM2:      cmd.op = pte_pkg::OP_VM2;
      ST_V02:      cmd.op = pte_pkg::OP_V02;
      ST_V12:      cmd.op = pte_pkg::OP_V12;
      ST_TA:       cmd.op = pte_pkg::OP_TA;
      ST_TD:       cmd.op = pte_pkg::OP_TD;
      ST_DA:       cmd.op = pte_pkg::OP_DA;
      ST_DD:       cmd.op = pte_pkg::OP_DD;
      ST_PICK:     cmd.op = pte_pkg::OP_NONE;
      ST_CRUISE:   cmd.op = pte_pkg::OP_CRUISE;
      ST_AD:       cmd.op = pte_pkg::OP_AD;
      ST_PEAK_SQ:  cmd.op = pte_pkg::OP_PEAK_SQ;
      ST_PEAK_DIV: cmd.op = pte_pkg::OP_PEAK_DIV;
      ST_SEGS_DIV: cmd.op = pte_pkg::OP_SEGS_DIV;
      ST_EMIT:     cmd.op = pte_pkg::OP_EMIT;
      default:     cmd.op = pte_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: hw/rtl/pte_dp.sv
// ----------------------------------------------------------------------------
// pte_dp
// Datapath: configuration registers, path state, one shared multiplier,
// shared divider and square root units, and the output word register.
// ----------------------------------------------------------------------------
module pte_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  pte_pkg::cmd_t                    cmd,
  output pte_pkg::stat_t                   stat,
  pte_in_if.sink                           pts,
  pte_out_if.source                        res
);

  localparam int CNT_W  = pte_pkg::CNT_W;
  localparam int BIDX_W = pte_pkg::BIDX_W;
  localparam int NEAR_W = pte_pkg::NEAR_W;
  localparam int D2_W   = pte_pkg::D2_W;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // configuration
  logic signed [31:0] vx, vy;
  logic [23:0]        v0, v1, vm_raw, am_raw, vm, am;

  // current point
  logic signed [31:0] px, py;
  logic               last;
  logic [31:0]        sa, sb;
  logic               half;
  logic [NEAR_W-1:0]  na, nb;
  logic               near;

  // path state
  logic signed [31:0] prev_x, prev_y;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        rl;
  logic [D2_W-1:0]    best_d2;
  logic [BIDX_W-1:0]  best_idx;
  logic signed [31:0] best_x, best_y;
  logic [31:0]        lab;

  // work registers
  logic [63:0] prod, acc;
  logic [32:0] seg;
  logic [31:0] dist_r, vp, time_r;
  logic [47:0] r_vm2, r_v02, r_v12, r_da, r_dd;
  logic [63:0] t_acc;

  // combinational helpers
  logic signed [32:0] dsx, dsy, dvx, dvy;
  logic [31:0]        ax, ay, mx, my;
  logic               take;
  logic [31:0]        ma, mb;
  logic               mul_en;
  logic [31:0]        rem_len;
  logic [33:0]        rl_sum;
  logic [31:0]        rl_new;
  logic [D2_W-1:0]    d2;
  logic [CNT_W-1:0]   segs;
  logic               need_time, speed_bad, out_free;
  logic [47:0]        cr_left;
  logic [31:0]        s0, s1;
  logic [32:0]        ssum;
  logic               div_run, sqrt_run, div_done, sqrt_done;
  logic [63:0]        div_num, div_q, sq_rad;
  logic [31:0]        div_den, sq_root;

  assign vm = (vm_raw == '0) ? 24'd1 : vm_raw;
  assign am = (am_raw == '0) ? 24'd1 : am_raw;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vx     <= '0;
      vy     <= '0;
      v0     <= '0;
      v1     <= '0;
      vm_raw <= 24'd655360;
      am_raw <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pte_pkg::REG_VEHICLE_X:   vx     <= cfg_data;
        pte_pkg::REG_VEHICLE_Y:   vy     <= cfg_data;
        pte_pkg::REG_START_SPEED: v0     <= cfg_data[23:0];
        pte_pkg::REG_END_SPEED:   v1     <= cfg_data[23:0];
        pte_pkg::REG_SPEED_LIMIT: vm_raw <= cfg_data[23:0];
        pte_pkg::REG_ACCEL_LIMIT: am_raw <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // input word: differences to previous point and to vehicle
  assign take     = (cmd.op == pte_pkg::OP_LOAD) && pts.valid;
  assign pts.ready = (cmd.op == pte_pkg::OP_LOAD);
  assign dsx = 33'(pts.point_x) - 33'(prev_x);
  assign dsy = 33'(pts.point_y) - 33'(prev_y);
  assign dvx = 33'(pts.point_x) - 33'(vx);
  assign dvy = 33'(pts.point_y) - 33'(vy);
  assign ax  = mag33(dsx);
  assign ay  = mag33(dsy);
  assign mx  = mag33(dvx);
  assign my  = mag33(dvy);

  always_ff @(posedge clk) begin
    if (take) begin
      px   <= pts.point_x;
      py   <= pts.point_y;
      last <= pts.last_point;
      half <= ax[31] | ay[31];
      sa   <= (ax[31] | ay[31]) ? {1'b0, ax[31:1]} : ax;
      sb   <= (ax[31] | ay[31]) ? {1'b0, ay[31:1]} : ay;
      near <= (mx < 32'(pte_pkg::NEAR_RAW)) && (my < 32'(pte_pkg::NEAR_RAW));
      na   <= mx[NEAR_W-1:0];
      nb   <= my[NEAR_W-1:0];
    end
  end

  // shared multiplier operands
  assign rem_len = rl - lab;
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd.op)
      pte_pkg::OP_SEG_MA: begin ma = sa; mb = sa; end
      pte_pkg::OP_SEG_MB: begin ma = sb; mb = sb; end
      pte_pkg::OP_NEAR_A: begin ma = 32'(na); mb = 32'(na); end
      pte_pkg::OP_NEAR_B: begin ma = 32'(nb); mb = 32'(nb); end
      pte_pkg::OP_VM2:    begin ma = 32'(vm); mb = 32'(vm); end
      pte_pkg::OP_V02:    begin ma = 32'(v0); mb = 32'(v0); end
      pte_pkg::OP_V12:    begin ma = 32'(v1); mb = 32'(v1); end
      pte_pkg::OP_AD:     begin ma = 32'(am); mb = rem_len; end
      default:            mul_en = 1'b0;
    endcase
  end

  // product register and square holding
  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
    if (cmd.op == pte_pkg::OP_SEG_MB || cmd.op == pte_pkg::OP_NEAR_B) acc <= prod;
    if (cmd.op == pte_pkg::OP_V02) r_vm2 <= prod[47:0];
    if (cmd.op == pte_pkg::OP_V12) r_v02 <= prod[47:0];
    if (cmd.op == pte_pkg::OP_TA)  r_v12 <= prod[47:0];
  end

  // square root operand
  always_comb begin
    case (cmd.op)
      pte_pkg::OP_SEG_SQ:  sq_rad = acc + prod;
      pte_pkg::OP_DIST_SQ: sq_rad = 64'(best_d2);
      pte_pkg::OP_PEAK_SQ: sq_rad = prod + 64'((49'(r_v02) + 49'(r_v12)) >> 1);
      default:             sq_rad = '0;
    endcase
  end
  assign sqrt_run = (cmd.op == pte_pkg::OP_SEG_SQ) || (cmd.op == pte_pkg::OP_DIST_SQ) ||
                    (cmd.op == pte_pkg::OP_PEAK_SQ);

  // divider operands
  assign cr_left = 48'(rem_len) - r_da - r_dd;
  assign s0      = (vp > 32'(v0)) ? vp - 32'(v0) : '0;
  assign s1      = (vp > 32'(v1)) ? vp - 32'(v1) : '0;
  assign ssum    = 33'(s0) + 33'(s1);
  assign segs    = cnt - CNT_W'(1) - CNT_W'(best_idx);
  always_comb begin
    div_run = 1'b1;
    div_num = '0;
    div_den = 32'(am);
    case (cmd.op)
      pte_pkg::OP_TA:       div_num = 64'({vm - v0, 16'h0000});
      pte_pkg::OP_TD:       div_num = 64'({vm - v1, 16'h0000});
      pte_pkg::OP_DA: begin
        div_num = 64'(r_vm2 - r_v02);
        div_den = 32'({am, 1'b0});
      end
      pte_pkg::OP_DD: begin
        div_num = 64'(r_vm2 - r_v12);
        div_den = 32'({am, 1'b0});
      end
      pte_pkg::OP_CRUISE: begin
        div_num = 64'({cr_left[31:0], 16'h0000});
        div_den = 32'(vm);
      end
      pte_pkg::OP_PEAK_DIV: div_num = 64'({ssum, 16'h0000});
      pte_pkg::OP_SEGS_DIV: begin
        div_num = t_acc;
        div_den = 32'(segs);
      end
      default:              div_run = 1'b0;
    endcase
  end

  pte_div u_div (
    .clk  (clk),
    .rst  (rst),
    .run  (div_run),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  pte_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .run  (sqrt_run),
    .rad  (sq_rad),
    .done (sqrt_done),
    .root (sq_root)
  );

  // unit results
  always_ff @(posedge clk) begin
    if (sqrt_done) begin
      case (cmd.op)
        pte_pkg::OP_SEG_SQ:  seg    <= half ? {sq_root, 1'b0} : {1'b0, sq_root};
        pte_pkg::OP_DIST_SQ: dist_r <= sq_root;
        pte_pkg::OP_PEAK_SQ: vp     <= sq_root;
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd.op)
        pte_pkg::OP_TA:       t_acc <= div_q;
        pte_pkg::OP_TD:       t_acc <= t_acc + div_q;
        pte_pkg::OP_DA:       r_da  <= div_q[47:0];
        pte_pkg::OP_DD:       r_dd  <= div_q[47:0];
        pte_pkg::OP_CRUISE:   t_acc <= t_acc + div_q;
        pte_pkg::OP_PEAK_DIV: t_acc <= div_q;
        pte_pkg::OP_SEGS_DIV: time_r <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
        default: ;
      endcase
    end
  end

  // running length with saturation, squared distance to vehicle
  assign rl_sum = 34'(rl) + ((cnt != '0) ? 34'(seg) : 34'd0);
  assign rl_new = (rl_sum[33:32] != 2'b00) ? '1 : rl_sum[31:0];
  assign d2     = D2_W'(acc + prod);

  // path state update and clear after the result
  always_ff @(posedge clk) begin
    if (rst || (cmd.op == pte_pkg::OP_EMIT && out_free)) begin
      cnt      <= '0;
      rl       <= '0;
      best_d2  <= pte_pkg::NEAR_D2;
      best_idx <= '0;
      best_x   <= '0;
      best_y   <= '0;
      lab      <= '0;
    end else if (cmd.op == pte_pkg::OP_UPDATE &&
                 cnt < CNT_W'(pte_pkg::MAX_POINTS)) begin
      rl  <= rl_new;
      cnt <= cnt + CNT_W'(1);
      if (cnt == '0) begin
        best_x <= px;
        best_y <= py;
      end
      if (near && d2 < best_d2) begin
        best_d2  <= d2;
        best_idx <= BIDX_W'(cnt);
        best_x   <= px;
        best_y   <= py;
        lab      <= rl_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pte_pkg::OP_UPDATE && cnt < CNT_W'(pte_pkg::MAX_POINTS)) begin
      prev_x <= px;
      prev_y <= py;
    end
  end

  // status toward the controller
  assign need_time = (cnt != '0) && (CNT_W'(best_idx) + CNT_W'(1) < cnt);
  assign speed_bad = (v0 > vm) || (v1 > vm);
  assign out_free  = !res.valid || res.ready;

  assign stat.in_valid  = pts.valid;
  assign stat.last      = last;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.need_time = need_time;
  assign stat.speed_bad = speed_bad;
  assign stat.cruise    = (49'(r_da) + 49'(r_dd)) < 49'(rem_len);
  assign stat.out_free  = out_free;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.op == pte_pkg::OP_EMIT && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pte_pkg::OP_EMIT && out_free) begin
      res.nearest_index    <= 16'(best_idx);
      res.nearest_x        <= best_x;
      res.nearest_y        <= best_y;
      res.nearest_distance <= dist_r;
      res.segment_time     <= (need_time && !speed_bad) ? time_r : '0;
      res.status           <= need_time && speed_bad;
    end
  end

endmodule

FILE: hw/rtl/path_time_interval_estimator_unit.sv
// Each point runs through the segment square root; the last point adds a distance
// root and, when a time is due, profile math on the shared divider.
// Throughput: one point at a time; the next point is taken once the previous
// one is done, even while a result word waits at the output.
// Reset (synchronous, rst high) restores register defaults and clears the path.
// ----------------------------------------------------------------------------
// path_time_interval_estimator_unit
// Nearest path point and trapezoid or triangle speed profile time per remaining segment.
// ----------------------------------------------------------------------------
module path_time_interval_estimator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  pte_in_if.sink                        pts,
  pte_out_if.source                     res
);

  pte_pkg::cmd_t  cmd;
  pte_pkg::stat_t stat;

  pte_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pte_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .pts       (pts),
    .res       (res)
  );

  // a result word appears only out of the emit step
  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(cmd.op == pte_pkg::OP_EMIT))
    else $error("result word without emit step");

  // an accepted point leaves the load step
  a_load_leaves: assert property (@(posedge clk) disable iff (rst)
    (pts.valid && pts.ready) |=> (cmd.op != pte_pkg::OP_LOAD))
    else $error("controller stayed in load after accept");

  // divider and root never finish together
  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    !(stat.div_done && stat.sqrt_done))
    else $error("divider and root done together");

endmodule

FILE: tb/sv/pte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_checker
// Watches the register port and both channels of the path time interval
// estimator, predicts each estimate from the accepted points and compares it
// field by field with the estimate that comes out.
// ----------------------------------------------------------------------------
module pte_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  pte_in_if.sink                        pts,
  pte_out_if.sink                       res,
  output int                            pending,
  output int                            errors
);

  localparam longint unsigned NEAR_LIM = 64'd1000 << 16;
  localparam longint unsigned SAT      = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] index;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] distance;
    logic [31:0] interval;
    logic        status;
  } estimate_t;

  estimate_t estimates[$];

  // register copies
  logic signed [31:0] veh_x, veh_y;
  logic [23:0]        v_start, v_end, v_limit, a_limit;

  // path state
  longint unsigned n_points;
  longint          last_x, last_y;
  longint unsigned path_len, best_d2, len_best;
  longint unsigned best_idx;
  longint          best_x, best_y;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function void clear_path();
    n_points = 0;
    last_x   = 0;
    last_y   = 0;
    path_len = 0;
    best_d2  = NEAR_LIM * NEAR_LIM;
    best_idx = 0;
    best_x   = 0;
    best_y   = 0;
    len_best = 0;
  endfunction

  // trapezoid or triangle travel time over the remaining length
  function automatic longint unsigned travel_time(longint unsigned rem_len);
    longint unsigned v0, v1, vm, acc, ta, td, da, dd, vp, s0, s1;
    v0  = v_start;
    v1  = v_end;
    vm  = (v_limit == 0) ? 1 : v_limit;
    acc = (a_limit == 0) ? 1 : a_limit;
    ta  = ((vm - v0) << 16) / acc;
    td  = ((vm - v1) << 16) / acc;
    da  = (vm * vm - v0 * v0) / (2 * acc);
    dd  = (vm * vm - v1 * v1) / (2 * acc);
    if (da + dd < rem_len) return ta + td + (((rem_len - da - dd) << 16) / vm);
    vp = root64(acc * rem_len + ((v0 * v0 + v1 * v1) >> 1));
    s0 = (vp > v0) ? vp - v0 : 0;
    s1 = (vp > v1) ? vp - v1 : 0;
    return ((s0 + s1) << 16) / acc;
  endfunction

  function void take_point(logic signed [31:0] px, logic signed [31:0] py, logic last);
    longint          x, y, dx, dy;
    longint unsigned ma, mb, seg, d2, vm, t;
    estimate_t       e;
    x = px;
    y = py;
    if (n_points < pte_pkg::MAX_POINTS) begin
      if (n_points > 0) begin
        ma = absval(x - last_x);
        mb = absval(y - last_y);
        if ((ma | mb) >= (64'd1 << 31))
          seg = root64((ma >> 1) * (ma >> 1) + (mb >> 1) * (mb >> 1)) << 1;
        else
          seg = root64(ma * ma + mb * mb);
        path_len = path_len + seg;
        if (path_len > SAT) path_len = SAT;
      end
      last_x = x;
      last_y = y;
      if (n_points == 0) begin
        best_x = x;
        best_y = y;
      end
      dx = x - longint'(veh_x);
      dy = y - longint'(veh_y);
      if (absval(dx) < NEAR_LIM && absval(dy) < NEAR_LIM) begin
        d2 = absval(dx) * absval(dx) + absval(dy) * absval(dy);
        if (d2 < best_d2) begin
          best_d2  = d2;
          best_idx = n_points;
          best_x   = x;
          best_y   = y;
          len_best = path_len;
        end
      end
      n_points = n_points + 1;
    end
    if (!last) return;
    e = '0;
    if (n_points != 0 && best_idx + 1 < n_points) begin
      vm = (v_limit == 0) ? 1 : v_limit;
      if (v_start > vm || v_end > vm) begin
        e.status = 1'b1;
      end else begin
        t = travel_time(path_len - len_best) / (n_points - 1 - best_idx);
        if (t > SAT) t = SAT;
        e.interval = t[31:0];
      end
    end
    e.index    = best_idx[15:0];
    e.x        = best_x[31:0];
    e.y        = best_y[31:0];
    e.distance = 32'(root64(best_d2));
    estimates.push_back(e);
    clear_path();
  endfunction

  // everything settles after the driving edge, so look at mid cycle
  always @(negedge clk) begin
    estimate_t want, got;
    if (rst) begin
      veh_x   = '0;
      veh_y   = '0;
      v_start = '0;
      v_end   = '0;
      v_limit = 24'd655360;
      a_limit = 24'd65536;
      clear_path();
      estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pte_pkg::REG_VEHICLE_X:   veh_x   = cfg_data;
          pte_pkg::REG_VEHICLE_Y:   veh_y   = cfg_data;
          pte_pkg::REG_START_SPEED: v_start = cfg_data[23:0];
          pte_pkg::REG_END_SPEED:   v_end   = cfg_data[23:0];
          pte_pkg::REG_SPEED_LIMIT: v_limit = cfg_data[23:0];
          pte_pkg::REG_ACCEL_LIMIT: a_limit = cfg_data[23:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = {res.nearest_index, res.nearest_x, res.nearest_y, res.nearest_distance,
               res.segment_time, res.status};
        if (estimates.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected estimate word %h", got);
        end else begin
          want = estimates.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("estimate mismatch: idx %0d/%0d x %h/%h y %h/%h dist %h/%h t %h/%h st %b/%b",
                       want.index, got.index, want.x, got.x, want.y, got.y,
                       want.distance, got.distance, want.interval, got.interval,
                       want.status, got.status);
          end
        end
      end
      if (pts.valid && pts.ready) take_point(pts.point_x, pts.point_y, pts.last_point);
    end
    pending = estimates.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end
endmodule

FILE: tb/sv/tb_path_time_interval_estimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_time_interval_estimator_unit
// Feeds directed and random paths through the estimator under several
// configurations and flow control patterns; the checker judges every word.
// ----------------------------------------------------------------------------
module tb_path_time_interval_estimator_unit;

  localparam int CYCLE_LIMIT = 4000000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [pte_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  int                            pending, errors;
  int                            cycles = 0;
  int                            tx_idle_pct = 0, rx_stall_pct = 0;
  int                            hold_left = 0;
  logic                          hold_req = 1'b0;
  logic                          point_taken = 1'b0;
  int                            n_items = 0;

  pte_in_if  pts ();
  pte_out_if res ();

  path_time_interval_estimator_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pts(pts.sink), .res(res.source)
  );

  pte_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pts(pts.sink), .res(res.sink), .pending(pending), .errors(errors)
  );

  always #5 clk = ~clk;

  // handshake seen mid cycle, used at the next edge
  always @(negedge clk) point_taken <= pts.valid && pts.ready;

  // receiver: random stalls plus a long hold-off requested in one phase
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_left = 3000;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // register write; the caller drops the enable after the last one
  task automatic write_reg(logic [pte_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] vx, logic [31:0] vy, logic [23:0] v0,
                         logic [23:0] v1, logic [23:0] vm, logic [23:0] acc);
    write_reg(pte_pkg::REG_VEHICLE_X, vx);
    write_reg(pte_pkg::REG_VEHICLE_Y, vy);
    write_reg(pte_pkg::REG_START_SPEED, {8'd0, v0});
    write_reg(pte_pkg::REG_END_SPEED, {8'd0, v1});
    write_reg(pte_pkg::REG_SPEED_LIMIT, {8'd0, vm});
    write_reg(pte_pkg::REG_ACCEL_LIMIT, {8'd0, acc});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every estimate, then let the block settle
  task automatic drain();
    pts.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      pts.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    pts.valid      <= 1'b1;
    pts.point_x    <= x;
    pts.point_y    <= y;
    pts.last_point <= last;
    @(posedge clk);
    while (!point_taken) @(posedge clk);
    n_items++;
  endtask

  // coordinate around a center: mostly within the near window, sometimes anywhere
  function automatic logic [31:0] near_coord(logic [31:0] c);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return $urandom;
    if (r < 50) return c + $urandom_range(65536 * 40) - 65536 * 20;
    return c + $urandom_range(65536 * 2400) - 65536 * 1200;
  endfunction

  function automatic logic [23:0] rand_speed();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 24'd0;
    if (r == 1) return 24'hFFFFFF;
    if (r < 6) return 24'($urandom_range(65536 * 30));
    return 24'($urandom);
  endfunction

  task automatic rand_config();
    logic [31:0] vx, vy;
    logic [23:0] vm;
    vx = ($urandom_range(9) == 0) ? $urandom : $urandom_range(65536 * 4000) - 65536 * 2000;
    vy = ($urandom_range(9) == 0) ? $urandom : $urandom_range(65536 * 4000) - 65536 * 2000;
    vm = rand_speed();
    if ($urandom_range(3) != 0)
      set_all(vx, vy, 24'($urandom_range(vm)), 24'($urandom_range(vm)), vm, rand_speed());
    else
      set_all(vx, vy, rand_speed(), rand_speed(), vm, rand_speed());
  endtask

  task automatic rand_path(logic [31:0] vx, logic [31:0] vy);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    for (int i = 0; i < n; i++) send_point(near_coord(vx), near_coord(vy), i == n - 1);
  endtask

  initial begin
    logic [31:0] vx, vy;
    pts.valid      <= 1'b0;
    pts.point_x    <= '0;
    pts.point_y    <= '0;
    pts.last_point <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: single point path, nearest is last
    send_point(32'd0, 32'd0, 1'b1);
    // cruise over a long straight path
    for (int i = 0; i < 4; i++) send_point(i * 32'h0064_0000, 32'd0, i == 3);
    // no point near enough: falls back to index 0
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    drain();

    // start speed above the limit
    set_all(32'h0001_0000, 32'hFFFF_0000, 24'hFFFFFF, 24'd0, 24'd65536, 24'hFFFFFF);
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'h0002_0000, 32'd0, 1'b1);
    drain();
    // zero limit registers act as raw one
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 24'd0, 24'd0, 24'd0, 24'd0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8001_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8003_0000, 32'h7FFE_0000, 1'b1);
    drain();
    // short path with fast boundary speeds: peak below a boundary speed
    set_all(32'd0, 32'd0, 24'h0A_0000, 24'h00_8000, 24'hFFFFFF, 24'h00_0100);
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'h0000_0100, 32'd0, 1'b0);
    send_point(32'h0000_0200, 32'h0000_0100, 1'b1);
    drain();

    // random paths across idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      rand_config();
      vx = chk.veh_x;
      vy = chk.veh_y;
      if (ph == 2) hold_req = 1'b1;
      while (n_items < 100 + (ph + 1) * 360) begin
        rand_path(vx, vy);
        hold_req = 1'b0;
        if ($urandom_range(5) == 0) begin
          drain();
          rand_config();
          vx = chk.veh_x;
          vy = chk.veh_y;
        end
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/pte_pkg.sv
hw/rtl/pte_if.sv
hw/rtl/pte_div.sv
hw/rtl/pte_sqrt.sv
hw/rtl/pte_ctrl.sv
hw/rtl/pte_dp.sv
hw/rtl/path_time_interval_estimator_unit.sv
tb/sv/pte_checker.sv
tb/sv/tb_path_time_interval_estimator_unit.sv
